@@ sv/wpat_pkg.sv @@
package wpat_pkg;

  // default sizes
  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 22;

  // operation codes
  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_POP       = 3'd1,
    OP_MARK_AV   = 3'd2,
    OP_MARK_UNAV = 3'd3,
    OP_QUERY     = 3'd4,
    OP_FIND      = 3'd5
  } op_t;

  // response status codes
  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

endpackage

@@ sv/wpat_if.sv @@
interface wpat_in_if #(
  parameter int ID_BITS = wpat_pkg::ID_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic [ID_BITS-1:0] worker_id;

  modport source (output valid, output operation, output worker_id, input ready);
  modport sink   (input valid, input operation, input worker_id, output ready);
endinterface

interface wpat_out_if #(
  parameter int DEPTH   = wpat_pkg::DEPTH_DEF,
  parameter int ID_BITS = wpat_pkg::ID_BITS_DEF
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [ID_BITS-1:0] result_id;
  logic               available;
  logic               is_member;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, output status, output result_id, output available,
                  output is_member, output entry_count, input ready);
  modport sink   (input valid, input status, input result_id, input available,
                  input is_member, input entry_count, output ready);
endinterface

@@ sv/worker_pool_availability_table.sv @@
// Worker pool availability table: an ordered pool of worker ids, oldest
// first, each with an availability flag, held in one synchronous RAM.
// Channels: in_req carries a request (operation, worker_id); out_rsp
// returns exactly one response per request (status, result_id, available,
// is_member, entry_count). Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high.
// One request is worked on at a time. in_req.ready is high while the
// sequencer is idle, also while an earlier response still waits in the
// output register.
// Push reads no entry and pop reads at most the oldest one; mark, query
// and find walk the entries from the oldest, one RAM read per cycle, and
// stop at the first matching entry or after the last one. The RAM read
// port, one entry per cycle, sets the search length. The response is
// loaded into the output register as the sequencer leaves its final state.
// If the output register still holds a response the receiver has not
// taken, the next finished response waits in the sequencer's final state
// and the pool is not updated until the output register frees up.
// Synchronous reset (rst_n low) empties the pool; RAM contents are kept
// and never read before being written by a push.
module worker_pool_availability_table #(
  parameter int DEPTH   = wpat_pkg::DEPTH_DEF,
  parameter int ID_BITS = wpat_pkg::ID_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  wpat_in_if.sink    in_req,
  wpat_out_if.source out_rsp
);
  import wpat_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int ENT_W = ID_BITS + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    slot_inc = (s == IDX_LAST) ? '0 : s + 1'b1;
  endfunction

  // control state
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic               dvld_r, dvld_nxt;
  logic               out_valid_r, out_valid_nxt;

  // request and scan registers
  op_t                op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [IDX_W-1:0]   iss_slot_r, iss_slot_nxt;
  logic [CNT_W-1:0]   iss_cnt_r, iss_cnt_nxt;
  logic [CNT_W-1:0]   limit_r, limit_nxt;
  logic [IDX_W-1:0]   dslot_r, dslot_nxt;
  logic               hit_r, hit_nxt;
  logic [ID_BITS-1:0] hit_id_r, hit_id_nxt;
  logic               hit_flag_r, hit_flag_nxt;
  logic [IDX_W-1:0]   hit_slot_r, hit_slot_nxt;

  // response registers
  status_t            out_status_r, out_status_nxt;
  logic [ID_BITS-1:0] out_rid_r, out_rid_nxt;
  logic               out_avail_r, out_avail_nxt;
  logic               out_member_r, out_member_nxt;
  logic [CNT_W-1:0]   out_count_r, out_count_nxt;

  // ram port signals
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENT_W-1:0]   wr_data;
  logic               rd_en;
  logic [ENT_W-1:0]   rd_data;
  logic [ID_BITS-1:0] rd_id;
  logic               rd_flag;

  logic accept, issue, match, hit_now, scan_done, fin_fire;

  wpat_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (iss_slot_r),
    .rd_data (rd_data)
  );

  assign rd_id   = rd_data[ENT_W-1:1];
  assign rd_flag = rd_data[0];

  // handshake and scan control
  assign accept    = in_req.valid && in_req.ready;
  assign issue     = (state_r == S_SCAN) && (iss_cnt_r != limit_r);
  assign rd_en     = issue;
  assign hit_now   = (state_r == S_SCAN) && dvld_r && match;
  assign scan_done = (state_r == S_SCAN) && (hit_now || !issue);
  assign fin_fire  = (state_r == S_FIN) && (!out_valid_r || out_rsp.ready);

  // entry match for the current operation
  always_comb begin
    case (op_r)
      OP_POP:  match = 1'b1;
      OP_FIND: match = rd_flag;
      default: match = (rd_id == id_r);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (scan_done) state_nxt = S_FIN;
      S_FIN:   if (fin_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt        = cnt_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    out_valid_nxt  = out_valid_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    iss_slot_nxt   = iss_slot_r;
    iss_cnt_nxt    = iss_cnt_r;
    limit_nxt      = limit_r;
    dvld_nxt       = issue;
    dslot_nxt      = iss_slot_r;
    hit_nxt        = hit_r;
    hit_id_nxt     = hit_id_r;
    hit_flag_nxt   = hit_flag_r;
    hit_slot_nxt   = hit_slot_r;
    out_status_nxt = out_status_r;
    out_rid_nxt    = out_rid_r;
    out_avail_nxt  = out_avail_r;
    out_member_nxt = out_member_r;
    out_count_nxt  = out_count_r;
    wr_en          = 1'b0;
    wr_addr        = tail_r;
    wr_data        = {id_r, 1'b0};

    // latch request and set scan length
    if (accept) begin
      op_nxt       = op_t'(in_req.operation);
      id_nxt       = in_req.worker_id;
      iss_slot_nxt = head_r;
      iss_cnt_nxt  = '0;
      hit_nxt      = 1'b0;
      case (op_t'(in_req.operation)) inside
        OP_POP:                                     limit_nxt = CNT_W'(cnt_r != '0);
        OP_MARK_AV, OP_MARK_UNAV, OP_QUERY, OP_FIND: limit_nxt = cnt_r;
        default:                                    limit_nxt = '0;
      endcase
    end

    // walk entries, one read issued per cycle
    if (issue) begin
      iss_slot_nxt = slot_inc(iss_slot_r);
      iss_cnt_nxt  = iss_cnt_r + 1'b1;
    end
    if (hit_now) begin
      hit_nxt      = 1'b1;
      hit_id_nxt   = rd_id;
      hit_flag_nxt = rd_flag;
      hit_slot_nxt = dslot_r;
    end

    // retire: update pool and load response
    if (fin_fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STS_OK;
      out_rid_nxt    = '0;
      out_avail_nxt  = 1'b0;
      out_member_nxt = 1'b0;
      unique case (op_r) inside
        OP_PUSH: begin
          if (cnt_r == CNT_FULL) begin
            out_status_nxt = STS_FULL;
          end else begin
            wr_en    = 1'b1;
            tail_nxt = slot_inc(tail_r);
            cnt_nxt  = cnt_r + 1'b1;
          end
        end
        OP_POP: begin
          if (hit_r) begin
            out_rid_nxt   = hit_id_r;
            out_avail_nxt = hit_flag_r;
            head_nxt      = slot_inc(head_r);
            cnt_nxt       = cnt_r - 1'b1;
          end else begin
            out_status_nxt = STS_EMPTY;
          end
        end
        OP_MARK_AV, OP_MARK_UNAV: begin
          if (hit_r) begin
            wr_en   = 1'b1;
            wr_addr = hit_slot_r;
            wr_data = {hit_id_r, op_r == OP_MARK_AV};
          end else begin
            out_status_nxt = STS_NOT_FOUND;
          end
        end
        OP_QUERY: begin
          if (hit_r) begin
            out_member_nxt = 1'b1;
            out_avail_nxt  = hit_flag_r;
          end else begin
            out_status_nxt = STS_NOT_FOUND;
          end
        end
        OP_FIND: begin
          if (hit_r) begin
            out_rid_nxt = hit_id_r;
          end else begin
            out_status_nxt = STS_NOT_FOUND;
          end
        end
        default: begin
          out_status_nxt = STS_OK;
        end
      endcase
      out_count_nxt = cnt_nxt;
    end else if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    iss_slot_r   <= iss_slot_nxt;
    iss_cnt_r    <= iss_cnt_nxt;
    limit_r      <= limit_nxt;
    dslot_r      <= dslot_nxt;
    hit_r        <= hit_nxt;
    hit_id_r     <= hit_id_nxt;
    hit_flag_r   <= hit_flag_nxt;
    hit_slot_r   <= hit_slot_nxt;
    out_status_r <= out_status_nxt;
    out_rid_r    <= out_rid_nxt;
    out_avail_r  <= out_avail_nxt;
    out_member_r <= out_member_nxt;
    out_count_r  <= out_count_nxt;
  end

  // port drive
  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.result_id   = out_rid_r;
  assign out_rsp.available   = out_avail_r;
  assign out_rsp.is_member   = out_member_r;
  assign out_rsp.entry_count = out_count_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above depth");

  a_pool_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN) |=> ($stable(cnt_r) && $stable(head_r) && $stable(tail_r)))
    else $error("pool pointers moved outside retire");

  a_scan_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_cnt_r <= limit_r && limit_r <= cnt_r))
    else $error("scan ran past the pool");

  a_retire_resp: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |=> out_valid_r)
    else $error("retired request without response");

endmodule

@@ sv/wpat_ram.sv @@
module wpat_ram #(
  parameter int DEPTH = wpat_pkg::DEPTH_DEF,
  parameter int WIDTH = wpat_pkg::ID_BITS_DEF + 1
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
